FILE: rtl/divider_timer_with_delayed_reload_top_assert.svh
// ----------------------------------------------------------------------------
// Divider timer assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DIVIDER_TIMER_WITH_DELAYED_RELOAD_TOP_ASSERT_SVH
`define DIVIDER_TIMER_WITH_DELAYED_RELOAD_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DTR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DTR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/dtr_pkg.sv
// ----------------------------------------------------------------------------
// Divider timer package
// Types, codes and next-state helpers shared by the timer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dtr_pkg;

  // Ticks between a counter overflow and the reload from the reload value.
  localparam int unsigned RELOAD_DELAY_TICKS = 4;

  localparam logic [7:0] CTRL_READ_ONES = 8'hF8;
  localparam logic [7:0] COUNT_MAX      = 8'hFF;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    REG_DIV     = 2'd0,
    REG_COUNT   = 2'd1,
    REG_RELOAD  = 2'd2,
    REG_CONTROL = 2'd3
  } reg_sel_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [1:0] reg_select;
    logic [7:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       timer_irq;
  } out_item_t;

  typedef struct packed {
    logic [15:0] div_count;
    logic [7:0]  timer_count;
    logic [7:0]  reload_value;
    logic [2:0]  control;
    logic        reload_pending;
    logic [2:0]  reload_delay;
    logic        reloading_now;
  } tmr_state_t;

  // Enabled divider bit selected by control bits 1:0.
  function automatic logic gated_input(logic [2:0] ctl, logic [15:0] div);
    logic bit_w;
    case (ctl[1:0])
      2'd1:    bit_w = div[3];
      2'd2:    bit_w = div[5];
      2'd3:    bit_w = div[7];
      default: bit_w = div[9];
    endcase
    return ctl[2] & bit_w;
  endfunction

  // One counter step; an overflow arms the delayed reload.
  function automatic tmr_state_t advance(tmr_state_t s);
    tmr_state_t r;
    r = s;
    if (!s.reload_pending) begin
      if (s.timer_count == COUNT_MAX) begin
        r.timer_count    = '0;
        r.reload_pending = 1'b1;
        r.reload_delay   = 3'(RELOAD_DELAY_TICKS);
      end else begin
        r.timer_count = s.timer_count + 8'd1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/dtr_in_if.sv
// ----------------------------------------------------------------------------
// Divider timer input channel
// Valid/ready channel carrying one operation word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dtr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [1:0] reg_select;
  logic [7:0] write_data;

  modport source (output valid, output operation, output reg_select,
                  output write_data, input ready);
  modport sink   (input valid, input operation, input reg_select,
                  input write_data, output ready);
endinterface

`default_nettype wire

FILE: rtl/dtr_out_if.sv
// ----------------------------------------------------------------------------
// Divider timer result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dtr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       timer_irq;

  modport source (output valid, output read_data, output timer_irq, input ready);
  modport sink   (input valid, input read_data, input timer_irq, output ready);
endinterface

`default_nettype wire

FILE: rtl/dtr_core.sv
// ----------------------------------------------------------------------------
// Divider timer core
// Holds the timer state and applies one operation word per enabled cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dtr_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire dtr_pkg::in_item_t item_i,
  output dtr_pkg::out_item_t    result_o
);
  import dtr_pkg::*;

  tmr_state_t st_q, st_d;
  out_item_t  res_w;

  // Next state and result for the word presented this cycle.
  always_comb begin
    st_d  = st_q;
    res_w = '0;
    case (op_e'(item_i.operation))
      OP_TICK: begin
        st_d.reloading_now = 1'b0;
        if (st_q.reload_pending) begin
          st_d.reload_delay = st_q.reload_delay - 3'd1;
          if (st_d.reload_delay == 3'd0) begin
            st_d.reloading_now  = 1'b1;
            st_d.timer_count    = st_q.reload_value;
            st_d.reload_pending = 1'b0;
            res_w.timer_irq     = 1'b1;
          end
        end
        st_d.div_count = st_q.div_count + 16'd1;
        if (gated_input(st_q.control, st_q.div_count) &&
            !gated_input(st_q.control, st_d.div_count)) begin
          st_d = advance(st_d);
        end
      end
      OP_READ: begin
        case (reg_sel_e'(item_i.reg_select))
          REG_DIV:    res_w.read_data = st_q.div_count[15:8];
          REG_COUNT:  res_w.read_data = st_q.timer_count;
          REG_RELOAD: res_w.read_data = st_q.reload_value;
          default:    res_w.read_data = {5'd0, st_q.control} | CTRL_READ_ONES;
        endcase
      end
      OP_WRITE: begin
        case (reg_sel_e'(item_i.reg_select))
          REG_DIV: begin
            st_d.div_count = '0;
            if (gated_input(st_q.control, st_q.div_count) &&
                !gated_input(st_q.control, 16'd0)) begin
              st_d = advance(st_d);
            end
          end
          REG_COUNT: begin
            // Ignored in the reload tick; otherwise cancels a pending reload.
            if (!st_q.reloading_now) begin
              st_d.reload_pending = 1'b0;
              if (st_q.reload_pending) begin
                st_d.reload_delay = '0;
              end
              st_d.timer_count = item_i.write_data;
            end
          end
          REG_RELOAD: begin
            st_d.reload_value = item_i.write_data;
            if (st_q.reloading_now) begin
              st_d.timer_count = item_i.write_data;
            end
          end
          default: begin
            st_d.control = item_i.write_data[2:0];
            if (gated_input(st_q.control, st_q.div_count) &&
                !gated_input(item_i.write_data[2:0], st_q.div_count)) begin
              st_d = advance(st_d);
            end
          end
        endcase
      end
      default: begin
        // Unused operation code: no effect, zero result.
        st_d = st_q;
      end
    endcase
  end

  // Timer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (en_i) begin
      st_q <= st_d;
    end
  end

  assign result_o = res_w;

endmodule

`default_nettype wire

FILE: rtl/divider_timer_with_delayed_reload_top.sv
// ----------------------------------------------------------------------------
// Divider timer with delayed reload
// Divider, counter, reload value and control registers driven by a word stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one word per handshake: a tick, a register read or a
//   register write. out_o returns exactly one result word for every input
//   word, in order: the read byte and the interrupt pulse flag.
//   A word accepted into the input register is applied to the timer state
//   once the output register is free, and at that edge its result is
//   loaded into the output register, where it is held until taken.
//   Throughput is one word per cycle while out_o.ready stays high.
//   in_i.ready stays high while the output register is empty or being
//   drained, so a result waiting to be taken still leaves room for one
//   more word in the input register.
//   While the receiver stalls, the result is held and, once the input
//   register is also full, in_i.ready drops until out_o.ready returns.
//   Reset clears the divider, counter, reload value, control and reload
//   state to zero and empties both registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "divider_timer_with_delayed_reload_top_assert.svh"

module divider_timer_with_delayed_reload_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dtr_in_if.sink    in_i,
  dtr_out_if.source out_o
);
  import dtr_pkg::*;

  logic      s1_valid_q, s1_valid_d;
  in_item_t  s1_item_q, s1_item_d;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;
  logic      out_free_w;
  logic      in_accept_w;
  logic      core_en_w;
  out_item_t core_res_w;

  // Handshake: the output register frees up when empty or being taken.
  assign out_free_w  = !out_valid_q || out_o.ready;
  assign in_i.ready  = !s1_valid_q || out_free_w;
  assign in_accept_w = in_i.valid && in_i.ready;
  assign core_en_w   = s1_valid_q && out_free_w;

  // Input register.
  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_item_d  = s1_item_q;
    if (in_accept_w) begin
      s1_valid_d = 1'b1;
      s1_item_d  = '{operation:  in_i.operation,
                     reg_select: in_i.reg_select,
                     write_data: in_i.write_data};
    end else if (core_en_w) begin
      s1_valid_d = 1'b0;
    end
  end

  dtr_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (core_en_w),
    .item_i  (s1_item_q),
    .result_o(core_res_w)
  );

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (core_en_w) begin
      out_valid_d = 1'b1;
      out_item_d  = core_res_w;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_item_q  <= s1_item_d;
    out_item_q <= out_item_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.read_data = out_item_q.read_data;
  assign out_o.timer_irq = out_item_q.timer_irq;

  // Assertions.
  `DTR_ASSERT_NEXT(a_accept_fills_stage, in_accept_w, s1_valid_q, "accepted word lost")
  `DTR_ASSERT_NEXT(a_stalled_word_kept, s1_valid_q && !out_free_w, s1_valid_q, "held word dropped")
  `DTR_ASSERT_NOW(a_irq_only_on_tick, core_en_w && core_res_w.timer_irq, s1_item_q.operation == OP_TICK && core_res_w.read_data == 8'd0, "interrupt outside a tick")

endmodule

`default_nettype wire
